[rtl/abd_pkg.sv]
// Shared types and address-map constants for the arcade bus decoder.
package abd_pkg;

  // Work RAM geometry
  localparam int RAM_DEPTH = 6144;
  localparam int RAM_AW    = 13;

  // Sprite copy source and destination offsets inside work RAM
  localparam int DMA_SRC = 'h0900;
  localparam int DMA_DST = 'h1000;
  localparam logic [RAM_AW-1:0] DMA_SRC_OFF = RAM_AW'(DMA_SRC);

  // Bus address map
  localparam logic [15:0] ROM_LIMIT  = 16'h4000;
  localparam logic [15:0] RAM_BASE   = 16'h6000;
  localparam logic [15:0] RAM_MASK_A = 16'hf000;
  localparam logic [15:0] RAM_MASK_B = 16'hf800;
  localparam logic [15:0] RAM_HIGH   = 16'h7000;
  localparam logic [15:0] NIB_MASK   = 16'hfff0;
  localparam logic [15:0] LATCH_MASK = 16'hfe00;
  localparam logic [15:0] JOY_BASE   = 16'h7c00;
  localparam logic [15:0] IDLE_BASE  = 16'h7c80;
  localparam logic [15:0] COIN_BASE  = 16'h7d00;
  localparam logic [15:0] DIP_BASE   = 16'h7d80;
  localparam logic [15:0] ADDR_EFFECT = 16'h7c00;
  localparam logic [15:0] ADDR_IRQ    = 16'h7d80;
  localparam logic [15:0] ADDR_NMI    = 16'h7d84;
  localparam logic [15:0] ADDR_DMA    = 16'h7d85;
  localparam logic [15:0] ADDR_COLOR0 = 16'h7d86;
  localparam logic [15:0] ADDR_COLOR1 = 16'h7d87;

  // Low-nibble codes inside the 0x7d0x group
  localparam logic [3:0] LO_SAMPLE_LAST = 4'h2;
  localparam logic [3:0] LO_PORT5       = 4'h3;
  localparam logic [3:0] LO_TEST1       = 4'h4;
  localparam logic [3:0] LO_TEST0       = 4'h5;

  localparam logic [7:0] OPEN_BUS = 8'hff;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // One RAM access cycle: one read port and one write port
  typedef struct packed {
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
  } ram_req_t;

  typedef struct packed {
    logic [7:0] effect;
    logic       port5;
    logic       test1;
    logic       test0;
    logic       irq_n;
    logic       nmi;
    logic [1:0] color;
  } latch_t;

endpackage

[rtl/arcade_bus_decoder_top.sv]
// Arcade main-CPU bus decoder top level: decode, latches, RAM and copy control.
//
// Each accepted request is one bus access and yields one result. Writes and
// non-RAM reads go straight into the result register; a work RAM read waits
// in ST_READ, since the RAM read port is registered. Writing an odd byte to
// 0x7d85 starts the sprite copy: its result is issued at once, then in_stall
// stays high while the copy sequencer moves one byte per cycle over the
// single RAM read and write port pair. Work RAM is not cleared by reset and
// reads as undefined until written. dip is set through cfg_we/cfg_wdata and
// resets to zero.
module arcade_bus_decoder_top #(
  parameter int DMA_LENGTH = 384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [6:0]  button_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        rom_access,
  output logic        sample_trigger,
  output logic [1:0]  sample_id,
  output logic [7:0]  effect_index,
  output logic        audio_port_bit5,
  output logic        audio_test1,
  output logic        audio_test0,
  output logic        audio_irq_n,
  output logic        nmi_enable,
  output logic [1:0]  color_table
);
  import abd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [7:0]  dip;
  latch_t      latches;
  latch_t      latches_next;

  logic        accept;
  logic        out_free;
  logic        ram_hit;
  logic        ram_rd;
  logic        ram_wr;
  logic        dma_go;
  logic [3:0]  lo;
  logic        bit0;
  logic [7:0]  rd_value;
  logic        trig;
  logic [RAM_AW-1:0] bus_off;

  ram_req_t    dma_req;
  ram_req_t    ram_req;
  logic        dma_active;
  logic [7:0]  ram_q;
  logic [7:0]  ram_wdata;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  assign ram_hit = ((address & RAM_MASK_A) == RAM_BASE) ||
                   ((address & RAM_MASK_B) == RAM_HIGH);
  assign bus_off = RAM_AW'(address - RAM_BASE);
  assign ram_rd  = accept && command == CMD_READ && address >= ROM_LIMIT && ram_hit;
  assign ram_wr  = accept && command == CMD_WRITE && ram_hit;
  assign lo      = address[3:0];
  assign bit0    = write_data[0];
  assign dma_go  = accept && command == CMD_WRITE && address == ADDR_DMA && bit0;

  // read data for everything but ROM and RAM
  always_comb begin
    rd_value = OPEN_BUS;
    if ((address & NIB_MASK) == JOY_BASE) begin
      rd_value = {3'b000, button_mask[4:0]};
    end else if ((address & NIB_MASK) == IDLE_BASE) begin
      rd_value = '0;
    end else if ((address & NIB_MASK) == COIN_BASE) begin
      rd_value = {button_mask[5], 4'b0000, button_mask[6], 2'b00};
    end else if ((address & NIB_MASK) == DIP_BASE) begin
      rd_value = dip;
    end
  end

  // latch updates for a write into 0x7c00-0x7dff
  always_comb begin
    latches_next = latches;
    trig         = 1'b0;
    if (command == CMD_WRITE && !ram_hit && (address & LATCH_MASK) == JOY_BASE) begin
      if (address == ADDR_EFFECT) latches_next.effect = write_data;
      if ((address & NIB_MASK) == COIN_BASE) begin
        trig = lo <= LO_SAMPLE_LAST && write_data != 8'h00;
        if (lo == LO_PORT5) latches_next.port5 = ~bit0;
        if (lo == LO_TEST1) latches_next.test1 = ~bit0;
        if (lo == LO_TEST0) latches_next.test0 = ~bit0;
      end
      if (address == ADDR_IRQ)    latches_next.irq_n    = ~bit0;
      if (address == ADDR_NMI)    latches_next.nmi      = bit0;
      if (address == ADDR_COLOR0) latches_next.color[0] = bit0;
      if (address == ADDR_COLOR1) latches_next.color[1] = bit0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ram_rd) begin
          state_next = ST_READ;
        end else if (dma_go) begin
          state_next = ST_COPY;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_COPY: begin
        if (!dma_active) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dip       <= '0;
      out_valid <= 1'b0;
      latches   <= '{effect: 8'h00, port5: 1'b0, test1: 1'b0, test0: 1'b0,
                     irq_n: 1'b1, nmi: 1'b0, color: 2'b00};
    end else begin
      state <= state_next;
      if (cfg_we) dip <= cfg_wdata;
      if (accept) begin
        latches   <= latches_next;
        out_valid <= !ram_rd;
      end else if (state == ST_READ) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data       <= '0;
      rom_access      <= 1'b0;
      sample_trigger  <= trig;
      sample_id       <= trig ? lo[1:0] : 2'b00;
      effect_index    <= latches_next.effect;
      audio_port_bit5 <= latches_next.port5;
      audio_test1     <= latches_next.test1;
      audio_test0     <= latches_next.test0;
      audio_irq_n     <= latches_next.irq_n;
      nmi_enable      <= latches_next.nmi;
      color_table     <= latches_next.color;
      if (command == CMD_READ) begin
        if (address < ROM_LIMIT) begin
          rom_access <= 1'b1;
        end else if (!ram_hit) begin
          read_data <= rd_value;
        end
      end
    end else if (state == ST_READ) begin
      read_data <= ram_q;
    end
  end

  // RAM port sharing: the bus never issues while a copy runs
  always_comb begin
    ram_req = dma_req;
    ram_wdata = ram_q;
    if (!dma_active) begin
      ram_req.rd_en   = ram_rd;
      ram_req.rd_addr = bus_off;
      ram_req.wr_en   = ram_wr;
      ram_req.wr_addr = bus_off;
      ram_wdata       = write_data;
    end
  end

  abd_dma #(
    .DMA_LENGTH(DMA_LENGTH)
  ) u_dma (
    .clk    (clk),
    .rst    (rst),
    .start  (dma_go),
    .req    (dma_req),
    .active (dma_active)
  );

  abd_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .wr_data (ram_wdata),
    .rd_data (ram_q)
  );

  assert property (@(posedge clk) disable iff (rst) ram_rd |=> !out_valid && state == ST_READ)
    else $error("RAM read result issued before data");
  assert property (@(posedge clk) disable iff (rst) state == ST_READ |=> out_valid)
    else $error("RAM read result dropped");
  assert property (@(posedge clk) disable iff (rst) dma_active |-> in_stall)
    else $error("request accepted during copy");
  assert property (@(posedge clk) disable iff (rst) dma_go |=> dma_active && out_valid)
    else $error("copy request lost its result or start");

endmodule

[rtl/abd_ram.sv]
// Work RAM: one write port and one registered read port.
module abd_ram (
  input  logic             clk,
  input  abd_pkg::ram_req_t req,
  input  logic [7:0]       wr_data,
  output logic [7:0]       rd_data
);
  import abd_pkg::*;

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/abd_dma.sv]
// Sprite copy sequencer: moves one RAM byte per cycle through the RAM ports.
module abd_dma #(
  parameter int DMA_LENGTH = 384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output abd_pkg::ram_req_t req,
  output logic              active
);
  import abd_pkg::*;

  // indices whose source or destination falls off the end of RAM are skipped
  localparam int DST_ROOM = RAM_DEPTH - DMA_DST;
  localparam int SRC_ROOM = RAM_DEPTH - DMA_SRC;
  localparam int ROOM     = (DST_ROOM < SRC_ROOM) ? DST_ROOM : SRC_ROOM;
  localparam int COPY_LEN = (DMA_LENGTH < ROOM) ? DMA_LENGTH : ROOM;
  localparam int CW       = $clog2(COPY_LEN + 1);
  localparam logic [CW-1:0] LAST = CW'(COPY_LEN - 1);

  logic              busy;
  logic              wr_pend;
  logic [CW-1:0]     count;
  logic [RAM_AW-1:0] wr_addr;
  logic [RAM_AW-1:0] rd_addr;

  assign rd_addr = DMA_SRC_OFF + RAM_AW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= busy;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
    end
    // destination trails the read into the next cycle, while the read data lands
    wr_addr <= rd_addr + RAM_AW'(DMA_DST - DMA_SRC);
  end

  always_comb begin
    req.rd_en   = busy;
    req.rd_addr = rd_addr;
    req.wr_en   = wr_pend;
    req.wr_addr = wr_addr;
  end

  assign active = busy | wr_pend;

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("copy did not start");
  assert property (@(posedge clk) disable iff (rst) busy && count == LAST |=> !busy)
    else $error("copy ran past its length");
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> wr_pend)
    else $error("last copy write lost");

endmodule
